// ===== rtl/core/sjf_pkg.sv =====
// Shared types and constants for the shortest-job-first scheduler.
// Used by sjf_ctrl, sjf_datapath and nonpreemptive_sjf_scheduler; no dependencies.
package sjf_pkg;

    localparam int TIME_W = 16;
    localparam int SLOT_OUT_W = 4;

    // Per-slot job status codes
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // One job table entry
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] remaining;
    } job_entry_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // store a job request
        logic start;  // open a tick, clear the candidate
        logic eval;   // table read data is valid for evaluation
        logic exec;   // run one time unit and emit the result
    } sjf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a new result
    } sjf_sts_t;

endpackage

// ===== rtl/core/sjf_ctrl.sv =====
// Controller state machine for the shortest-job-first scheduler.
// Depends on sjf_pkg; drives sjf_datapath through sjf_cmd_t and the table read address.
module sjf_ctrl
    import sjf_pkg::*;
#(
    parameter int MAX_JOBS = 16,
    parameter int IDX_W    = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             mode,
    output logic             s_tready,
    output sjf_cmd_t         cmd,
    output logic [IDX_W-1:0] rd_addr,
    input  sjf_sts_t         sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             eval_reg;
    logic             accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = idx_reg;

    // Decode commands
    always_comb
    begin
        cmd.load  = accept && !mode;
        cmd.start = accept && mode;
        cmd.eval  = eval_reg;
        cmd.exec  = (state_reg == S_EXEC) && sts.out_free;
    end

    // Next state and scan index
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept && mode)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, index and read-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            eval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            eval_reg  <= (state_reg == S_SCAN);
        end
    end

endmodule

// ===== rtl/core/sjf_datapath.sv =====
// Datapath of the shortest-job-first scheduler: job table memory, slot status,
// candidate search registers, running job, time counter and output register. Depends on sjf_pkg.
module sjf_datapath
    import sjf_pkg::*;
#(
    parameter int MAX_JOBS = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sjf_cmd_t              cmd,
    input  logic [IDX_W-1:0]      rd_addr,
    output sjf_sts_t              sts,
    input  logic [TIME_W-1:0]     arrival_time,
    input  logic [TIME_W-1:0]     burst_time,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SLOT_OUT_W-1:0] job_slot,
    output logic                  job_running,
    output logic                  job_finished,
    output logic [TIME_W-1:0]     tick_time
);

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_JOBS);

    job_entry_t           table_mem [MAX_JOBS];
    job_entry_t           rd_data_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [1:0]           status_reg [MAX_JOBS];
    logic [CNT_W-1:0]     loaded_reg;
    logic [TIME_W-1:0]    time_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_W-1:0]    best_rem_reg;
    logic [TIME_W-1:0]    best_arr_reg;
    logic                 busy_reg;
    logic [IDX_W-1:0]     cur_slot_reg;
    logic [TIME_W-1:0]    run_rem_reg;
    logic                 out_valid_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic                 out_running_reg;
    logic                 out_finished_reg;
    logic [TIME_W-1:0]    out_time_reg;

    logic                 load_ok;
    logic [1:0]           eval_status;
    logic                 admit;
    logic                 cand_ready;
    logic                 cand_better;
    logic                 run_go;
    logic [IDX_W-1:0]     run_slot;
    logic [TIME_W-1:0]    run_rem;
    logic [TIME_W-1:0]    new_rem;
    logic                 run_fin;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;

    assign load_ok = cmd.load && (loaded_reg < CAPACITY);

    // Table memory: one write port for loads, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            table_mem[loaded_reg[IDX_W-1:0]] <= '{arrival: arrival_time, remaining: burst_time};
        end
        rd_data_reg <= table_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    // Evaluate one scanned slot: admit it, then weigh it against the candidate
    always_comb
    begin
        eval_status = status_reg[rd_idx_reg];
        admit       = (eval_status == ST_WAIT) && (rd_data_reg.arrival <= time_reg);
        cand_ready  = (eval_status == ST_READY) || admit;
        cand_better = !found_reg
                   || (rd_data_reg.remaining < best_rem_reg)
                   || ((rd_data_reg.remaining == best_rem_reg)
                       && (rd_data_reg.arrival < best_arr_reg));
    end

    // Pick the job to run and advance it one unit
    always_comb
    begin
        run_go   = busy_reg || found_reg;
        run_slot = busy_reg ? cur_slot_reg : best_idx_reg;
        run_rem  = busy_reg ? run_rem_reg : best_rem_reg;
        new_rem  = run_rem - TIME_W'(1);
        run_fin  = (new_rem == '0);
        slot_ext = {{SLOT_OUT_W{1'b0}}, run_slot};
    end

    // Slot status: set on load, promote on admission, retire on completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                status_reg[i] <= ST_EMPTY;
            end
        end
        else
        begin
            if (load_ok)
            begin
                status_reg[loaded_reg[IDX_W-1:0]] <= (burst_time == '0) ? ST_DONE : ST_WAIT;
            end
            if (cmd.eval && admit)
            begin
                status_reg[rd_idx_reg] <= ST_READY;
            end
            if (cmd.exec && run_go && run_fin)
            begin
                status_reg[run_slot] <= ST_DONE;
            end
        end
    end

    // Control registers: fill count, time, candidate flag, running job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg   <= '0;
            time_reg     <= '0;
            found_reg    <= 1'b0;
            busy_reg     <= 1'b0;
            cur_slot_reg <= '0;
        end
        else
        begin
            if (load_ok)
            begin
                loaded_reg <= loaded_reg + CNT_W'(1);
            end
            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.eval && !busy_reg && cand_ready && cand_better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.exec)
            begin
                if (run_go)
                begin
                    cur_slot_reg <= run_slot;
                end
                busy_reg <= run_go && !run_fin;
                if (time_reg != '1)
                begin
                    time_reg <= time_reg + TIME_W'(1);
                end
            end
        end
    end

    // Candidate and running remaining time
    always_ff @(posedge clk)
    begin
        if (cmd.eval && !busy_reg && cand_ready && cand_better)
        begin
            best_idx_reg <= rd_idx_reg;
            best_rem_reg <= rd_data_reg.remaining;
            best_arr_reg <= rd_data_reg.arrival;
        end
        if (cmd.exec && run_go)
        begin
            run_rem_reg <= new_rem;
        end
    end

    // Output register: hold a result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_slot_reg     <= run_go ? slot_ext[SLOT_OUT_W-1:0] : '0;
            out_running_reg  <= run_go;
            out_finished_reg <= run_go && run_fin;
            out_time_reg     <= time_reg;
        end
    end

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign job_slot      = out_slot_reg;
    assign job_running   = out_running_reg;
    assign job_finished  = out_finished_reg;
    assign tick_time     = out_time_reg;

`ifndef NO_ASSERTIONS
    // A running job keeps its slot in the ready state
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> status_reg[cur_slot_reg] == ST_READY)
        else $error("running slot not in ready state");

    // A completing job releases the processor
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && run_go && run_fin) |=> !busy_reg)
        else $error("processor still busy after completion");

    // Every executed tick leaves a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("tick result missing");

    // Time only moves on an executed tick
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(time_reg))
        else $error("time changed outside a tick");

    // The fill count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CAPACITY)
        else $error("fill count beyond capacity");
`endif

endmodule

// ===== rtl/core/nonpreemptive_sjf_scheduler.sv =====
// Non-preemptive shortest-job-first scheduler. A request with tuser = 0 loads a job
// (ready time, burst) into the next free table slot; loads beyond MAX_JOBS are dropped,
// and a zero burst is stored as already done. A request with tuser = 1 is a tick: it
// admits jobs whose ready time has come, picks the ready job with the least remaining
// time (ties to earlier ready time, then lower slot) if none is running, runs it one
// unit and returns one result with the slot, running and finished flags and the tick's
// time, which saturates at 65535. The job table sits in a memory with one registered
// read port that a tick sweeps one slot per cycle, followed by a drain step for the last
// read and an execute step that loads the result register. No new request is accepted
// while a tick is in progress. The input is accepted again as soon as the tick's result
// is loaded, even while that result still waits downstream; a following tick then holds
// in its execute step until the result is taken.
// Depends on sjf_pkg, sjf_ctrl and sjf_datapath.
module nonpreemptive_sjf_scheduler
    import sjf_pkg::*;
#(
    parameter int MAX_JOBS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] arrival_time, [31:16] burst_time
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [3:0] job_slot, [4] job_running, [5] job_finished,
                                   // [21:6] tick_time, [23:22] zero
);

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    sjf_cmd_t              cmd;
    sjf_sts_t              sts;
    logic [IDX_W-1:0]      rd_addr;
    logic [SLOT_OUT_W-1:0] job_slot;
    logic                  job_running;
    logic                  job_finished;
    logic [TIME_W-1:0]     tick_time;

    sjf_ctrl #(
        .MAX_JOBS (MAX_JOBS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .sts      (sts)
    );

    sjf_datapath #(
        .MAX_JOBS (MAX_JOBS),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .sts          (sts),
        .arrival_time (s_tdata[15:0]),
        .burst_time   (s_tdata[31:16]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .job_slot     (job_slot),
        .job_running  (job_running),
        .job_finished (job_finished),
        .tick_time    (tick_time)
    );

    // Pack the result fields
    assign m_tdata = {2'b00, tick_time, job_finished, job_running, job_slot};

endmodule
